FILE: src/pbu_pkg.sv
// shared types, codes and arithmetic helpers for the pixel blend unit
package pbu_pkg;

	// access kinds carried in the func field
	localparam logic FUNC_BLEND = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// blend modes carried in the blend_mode field
	localparam logic [1:0] MODE_REPLACE = 2'd0;
	localparam logic [1:0] MODE_ALPHA   = 2'd1;
	localparam logic [1:0] MODE_ADD     = 2'd2;
	localparam logic [1:0] MODE_MUL     = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam int unsigned CFG_DATA_W  = 9;
	localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RST = 9'd256;

	// pixel packing
	localparam int unsigned COORD_W = 16;
	localparam int unsigned PIX_W   = 32;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned NUM_COLOR_CHAN = 3;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef logic [PIX_W-1:0] pixel_t;

	// exact floor(x / 255) for x up to 255 * 255
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		begin
			t = 17'(x) + 17'(x[15:8]) + 17'd1;
			div255 = t[15:8];
		end
	endfunction

endpackage

FILE: src/pbu_if.sv
// request and response channel interfaces of the pixel blend unit
interface pbu_req_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic signed [pbu_pkg::COORD_W-1:0]  pos_x;
	logic signed [pbu_pkg::COORD_W-1:0]  pos_y;
	logic        [pbu_pkg::PIX_W-1:0]    src_color;
	logic        [1:0]                   blend_mode;

	modport source (output valid, func, pos_x, pos_y, src_color, blend_mode, input ready);
	modport sink   (input valid, func, pos_x, pos_y, src_color, blend_mode, output ready);
endinterface

interface pbu_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pbu_pkg::PIX_W-1:0]    pixel_color;
	logic                         in_bounds;
	logic                         written;

	modport source (output valid, pixel_color, in_bounds, written, input ready);
	modport sink   (input valid, pixel_color, in_bounds, written, output ready);
endinterface

FILE: src/pixel_blend_unit.sv
// pixel blend unit: frame store with read-modify-write blending (replace, alpha, add, multiply)
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   req      | in  | func, pos_x, pos_y, src_color, blend_mode
//   rsp      | out | pixel_color, in_bounds, written
//   cfg      | in  | cfg_we, cfg_index, cfg_data (frame_width, frame_height)
//
// one pixel access is in flight at a time: frame store read, multiply, write-back,
// so a new request is taken only after the previous one has left the write-back step;
// the frame store read data and the per-channel products are registered between steps.
// after reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words of the store
// (65536 by default), with req.ready low; config writes are taken throughout.
// a stalled rsp holds the result register and the write-back of the next access.
module pixel_blend_unit #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pbu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbu_pkg::CFG_DATA_W-1:0]      cfg_data,
	pbu_req_if.sink                             req,
	pbu_rsp_if.source                           rsp
);

	localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
	localparam logic [16:0] MAX_H17 = 17'(MAX_HEIGHT);
	localparam int unsigned CW = pbu_pkg::CHAN_W;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_CALC  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [pbu_pkg::CFG_DATA_W-1:0] frame_width_q;
	logic [pbu_pkg::CFG_DATA_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pbu_pkg::FRAME_SIZE_RST;
			frame_height_q <= pbu_pkg::FRAME_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbu_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				pbu_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame size, clamped to 1..MAX
	logic [16:0] fw17, fh17, eff_w, eff_h;
	assign fw17 = {8'b0, frame_width_q};
	assign fh17 = {8'b0, frame_height_q};
	assign eff_w = (frame_width_q == '0) ? 17'd1 : ((fw17 > MAX_W17) ? MAX_W17 : fw17);
	assign eff_h = (frame_height_q == '0) ? 17'd1 : ((fh17 > MAX_H17) ? MAX_H17 : fh17);

	// bounds check and pixel address of the incoming transaction
	logic              req_inb;
	logic [ADDR_W-1:0] req_addr;
	logic              acc;

	assign req_inb = !req.pos_x[15] && !req.pos_y[15]
		&& ({1'b0, req.pos_x[15:0]} < eff_w) && ({1'b0, req.pos_y[15:0]} < eff_h);
	assign req_addr = ADDR_W'(32'(req.pos_y[15:0]) * 32'(MAX_WIDTH) + 32'(req.pos_x[15:0]));
	assign req.ready = (state_q == ST_IDLE);
	assign acc = req.valid && req.ready;

	// stage 1 registers, captured at accept
	logic                    func_s1;
	logic [1:0]              mode_s1;
	pbu_pkg::pixel_t         src_s1;
	logic                    inb_s1;
	logic [ADDR_W-1:0]       addr_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1 <= req.func;
			mode_s1 <= req.blend_mode;
			src_s1  <= req.src_color;
			inb_s1  <= req_inb;
			addr_s1 <= req_addr;
		end
	end

	// frame store
	pbu_pkg::pixel_t   mem [DEPTH];
	pbu_pkg::pixel_t   rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	pbu_pkg::pixel_t   mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (acc) begin
			rdata_q <= mem[req_addr];
		end
	end

	// per-channel products, summed ahead of the divide
	logic [CW-1:0] sa;
	logic [15:0]   sum_c [pbu_pkg::NUM_COLOR_CHAN];
	logic          wr_c, copy_c;

	assign sa = src_s1[31:24];

	always_comb begin
		logic [CW-1:0] s, d, m1, m2;
		logic [15:0]   p1, p2;
		for (int c = 0; c < pbu_pkg::NUM_COLOR_CHAN; c++) begin
			s = src_s1[c*CW +: CW];
			d = rdata_q[c*CW +: CW];
			m1 = '0;
			m2 = '0;
			case (mode_s1)
				pbu_pkg::MODE_ALPHA: begin
					m1 = sa;
					m2 = pbu_pkg::CHAN_MAX - sa;
				end
				pbu_pkg::MODE_ADD: begin
					m1 = sa;
				end
				pbu_pkg::MODE_MUL: begin
					m1 = d;
				end
				default: ;
			endcase
			p1 = 16'(s) * 16'(m1);
			p2 = 16'(d) * 16'(m2);
			sum_c[c] = 16'(17'(p1) + 17'(p2));
		end
	end

	assign copy_c = (mode_s1 == pbu_pkg::MODE_REPLACE) || (sa == pbu_pkg::CHAN_MAX);
	assign wr_c = inb_s1 && (func_s1 == pbu_pkg::FUNC_BLEND) && (copy_c || (sa != '0));

	// stage 2 registers
	logic [15:0]     sum_s2 [pbu_pkg::NUM_COLOR_CHAN];
	pbu_pkg::pixel_t dst_s2;
	logic            wr_s2, copy_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			sum_s2  <= sum_c;
			dst_s2  <= rdata_q;
			wr_s2   <= wr_c;
			copy_s2 <= copy_c;
		end
	end

	// final channel values
	pbu_pkg::pixel_t blend_word, new_word, out_word;

	always_comb begin
		logic [CW-1:0] q, d, da;
		logic [CW:0]   t;
		da = dst_s2[31:24];
		blend_word = '0;
		if (mode_s1 == pbu_pkg::MODE_ALPHA) begin
			blend_word[31:24] = (da > sa) ? da : sa;
		end else begin
			blend_word[31:24] = da;
		end
		for (int c = 0; c < pbu_pkg::NUM_COLOR_CHAN; c++) begin
			q = pbu_pkg::div255(sum_s2[c]);
			d = dst_s2[c*CW +: CW];
			t = {1'b0, d} + {1'b0, q};
			if (mode_s1 == pbu_pkg::MODE_ADD) begin
				blend_word[c*CW +: CW] = t[CW] ? pbu_pkg::CHAN_MAX : t[CW-1:0];
			end else begin
				blend_word[c*CW +: CW] = q;
			end
		end
	end

	assign new_word = copy_s2 ? src_s1 : blend_word;
	assign out_word = !inb_s1 ? '0 : (wr_s2 ? new_word : dst_s2);

	// write-back waits for a free result register
	logic done_go;
	assign done_go = (state_q == ST_DONE) && (!rsp.valid || rsp.ready);

	// clearing pass address
	logic [ADDR_W-1:0] clr_addr_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = new_word;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (done_go && wr_s2) begin
			mem_we = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	logic            out_valid_q;
	pbu_pkg::pixel_t out_color_q;
	logic            out_inb_q, out_wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_color_q <= out_word;
			out_inb_q   <= inb_s1;
			out_wr_q    <= wr_s2;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.pixel_color = out_color_q;
	assign rsp.in_bounds   = out_inb_q;
	assign rsp.written     = out_wr_q;

	// checks
	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_CALC))
		else $error("accepted transaction did not enter the multiply step");

	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q != ST_CLEAR)) |-> (inb_s1 && wr_s2 && done_go))
		else $error("frame store written outside a valid write-back");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.in_bounds) |-> ((rsp.pixel_color == '0) && !rsp.written))
		else $error("out-of-frame result carries data or a write");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request taken during clearing pass");

endmodule
